@@ rtl/taf_pkg.sv @@
package taf_pkg;

    localparam int TRACKS_DEFAULT = 8;

    localparam int TRACK_W  = 3;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 16;
    localparam int WIN_W    = 12;
    localparam int RSQ_W    = 2 * POS_W;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // 42 pt radius in 1/16 pt, squared
    localparam logic [RSQ_W-1:0] RADIUS_SQ_RESET = 32'd451584;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_TIME      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_RADIUS   = 3'd6;

    localparam logic [1:0] TAP_OFF     = 2'd0;
    localparam logic [1:0] TAP_INITIAL = 2'd1;
    localparam logic [1:0] TAP_FINAL   = 2'd2;

    typedef struct packed {
        logic              hold_enable;
        logic [WIN_W-1:0]  hold_time;
        logic              ignore_enable;
        logic [WIN_W-1:0]  ignore_time;
        logic [1:0]        tap_mode;
        logic [WIN_W-1:0]  tap_time;
        logic [RSQ_W-1:0]  radius_sq;
    } cfg_t;

    typedef struct packed {
        logic               trial_start;
        logic [TRACK_W-1:0] track;
        logic [TIME_W-1:0]  timestamp;
        logic [POS_W-1:0]   x_pos;
        logic [POS_W-1:0]   y_pos;
        logic               last_of_track;
    } item_t;

    typedef struct packed {
        logic [TRACK_W-1:0] out_track;
        logic [TIME_W-1:0]  out_timestamp;
        logic [POS_W-1:0]   out_x;
        logic [POS_W-1:0]   out_y;
    } result_t;

endpackage

@@ rtl/taf_cfg_regs.sv @@
module taf_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [taf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [taf_pkg::CFG_DATA_W-1:0] cfg_data,
    output taf_pkg::cfg_t                  cfg
);
    import taf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic write_en;

    assign cfg_ready = 1'b1;
    assign write_en  = cfg_valid & cfg_ready;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (write_en) begin
            case (cfg_index)
                REG_HOLD_ENABLE:   cfg_next.hold_enable   = cfg_data[0];
                REG_HOLD_TIME:     cfg_next.hold_time     = cfg_data[WIN_W-1:0];
                REG_IGNORE_ENABLE: cfg_next.ignore_enable = cfg_data[0];
                REG_IGNORE_TIME:   cfg_next.ignore_time   = cfg_data[WIN_W-1:0];
                REG_TAP_MODE:      cfg_next.tap_mode      = cfg_data[1:0];
                REG_TAP_TIME:      cfg_next.tap_time      = cfg_data[WIN_W-1:0];
                // only the square of the radius is ever used
                REG_MOVE_RADIUS:   cfg_next.radius_sq     = RSQ_W'(cfg_data) *
                                                            RSQ_W'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_enable   <= 1'b0;
            cfg_reg.hold_time     <= '0;
            cfg_reg.ignore_enable <= 1'b0;
            cfg_reg.ignore_time   <= '0;
            cfg_reg.tap_mode      <= TAP_OFF;
            cfg_reg.tap_time      <= '0;
            cfg_reg.radius_sq     <= RADIUS_SQ_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/taf_core.sv @@
module taf_core #(
    parameter int TRACKS = taf_pkg::TRACKS_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  taf_pkg::item_t  item,
    input  taf_pkg::cfg_t   cfg,
    output logic            emit,
    output taf_pkg::result_t result
);
    import taf_pkg::*;

    logic [TRACKS-1:0] down_reg, down_next;
    logic              active_reg, active_next;
    logic              tap_started_reg, tap_started_next;
    logic              rel_seen_reg, rel_seen_next;
    logic [TIME_W-1:0] hold_ref_reg, hold_ref_next;
    logic [TIME_W-1:0] tap_ref_reg, tap_ref_next;
    logic [TIME_W-1:0] rel_time_reg, rel_time_next;
    logic [POS_W-1:0]  first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic [POS_W-1:0]  anchor_x_reg, anchor_x_next, anchor_y_reg, anchor_y_next;

    // state as seen after an optional trial clear
    logic [TRACKS-1:0] down_c;
    logic              active_c, tap_started_c, rel_seen_c;
    logic [TIME_W-1:0] hold_ref_c, tap_ref_c, rel_time_c;
    logic [POS_W-1:0]  first_x_c, first_y_c, anchor_x_c, anchor_y_c;

    logic              in_range, drop_repeat, any_down, hold_sup, in_window, moved;
    logic [TIME_W-1:0] hold_ref_s, tap_ref_s;
    logic [POS_W-1:0]  first_x_s, first_y_s, anchor_x_s, anchor_y_s;
    logic [POS_W-1:0]  dx, dy;
    logic [RSQ_W:0]    dist_sq;
    logic [TRACKS-1:0] down_s;
    logic              emit_c;
    logic [POS_W-1:0]  ox, oy;

    always_comb begin
        if (item.trial_start) begin
            down_c        = '0;
            active_c      = 1'b0;
            tap_started_c = 1'b0;
            rel_seen_c    = 1'b0;
            hold_ref_c    = '0;
            tap_ref_c     = '0;
            rel_time_c    = '0;
            first_x_c     = '0;
            first_y_c     = '0;
            anchor_x_c    = '0;
            anchor_y_c    = '0;
        end else begin
            down_c        = down_reg;
            active_c      = active_reg;
            tap_started_c = tap_started_reg;
            rel_seen_c    = rel_seen_reg;
            hold_ref_c    = hold_ref_reg;
            tap_ref_c     = tap_ref_reg;
            rel_time_c    = rel_time_reg;
            first_x_c     = first_x_reg;
            first_y_c     = first_y_reg;
            anchor_x_c    = anchor_x_reg;
            anchor_y_c    = anchor_y_reg;
        end
    end

    always_comb begin
        in_range    = {29'd0, item.track} < 32'(TRACKS);
        drop_repeat = cfg.ignore_enable && rel_seen_c &&
                      ({1'b0, item.timestamp} <
                       {1'b0, rel_time_c} + {21'd0, cfg.ignore_time});

        hold_ref_s = active_c ? hold_ref_c : item.timestamp;
        first_x_s  = active_c ? first_x_c  : item.x_pos;
        first_y_s  = active_c ? first_y_c  : item.y_pos;

        for (int i = 0; i < TRACKS; i++) begin
            if ({29'd0, item.track} == 32'(i)) begin
                down_s[i] = !item.last_of_track;
            end else begin
                down_s[i] = down_c[i];
            end
        end
        any_down = |down_s;

        hold_sup = cfg.hold_enable &&
                   ({1'b0, item.timestamp} <
                    {1'b0, hold_ref_s} + {21'd0, cfg.hold_time});

        tap_ref_s  = tap_started_c ? tap_ref_c  : item.timestamp;
        anchor_x_s = tap_started_c ? anchor_x_c : item.x_pos;
        anchor_y_s = tap_started_c ? anchor_y_c : item.y_pos;
        in_window  = {1'b0, item.timestamp} <
                     {1'b0, tap_ref_s} + {21'd0, cfg.tap_time};

        dx = (anchor_x_s > item.x_pos) ? anchor_x_s - item.x_pos : item.x_pos - anchor_x_s;
        dy = (anchor_y_s > item.y_pos) ? anchor_y_s - item.y_pos : item.y_pos - anchor_y_s;
        dist_sq = {1'b0, RSQ_W'(dx) * RSQ_W'(dx)} + {1'b0, RSQ_W'(dy) * RSQ_W'(dy)};
        moved   = dist_sq >= {1'b0, cfg.radius_sq};

        // default: nothing but the trial clear takes effect
        down_next        = down_c;
        active_next      = active_c;
        tap_started_next = tap_started_c;
        rel_seen_next    = rel_seen_c;
        hold_ref_next    = hold_ref_c;
        tap_ref_next     = tap_ref_c;
        rel_time_next    = rel_time_c;
        first_x_next     = first_x_c;
        first_y_next     = first_y_c;
        anchor_x_next    = anchor_x_c;
        anchor_y_next    = anchor_y_c;
        emit_c           = 1'b0;
        ox               = item.x_pos;
        oy               = item.y_pos;

        if (in_range && !drop_repeat) begin
            down_next     = down_s;
            hold_ref_next = hold_ref_s;
            first_x_next  = first_x_s;
            first_y_next  = first_y_s;
            active_next   = 1'b1;
            if (hold_sup) begin
                active_next = any_down;
            end else begin
                tap_started_next = 1'b1;
                tap_ref_next     = tap_ref_s;
                anchor_x_next    = anchor_x_s;
                anchor_y_next    = anchor_y_s;
                emit_c           = 1'b1;
                case (cfg.tap_mode)
                    TAP_INITIAL: begin
                        if (in_window) begin
                            emit_c = !any_down;
                            ox     = first_x_s;
                            oy     = first_y_s;
                        end
                    end
                    TAP_FINAL: begin
                        if (in_window) begin
                            if (moved) begin
                                tap_ref_next  = item.timestamp;
                                anchor_x_next = item.x_pos;
                                anchor_y_next = item.y_pos;
                            end
                            emit_c = !any_down;
                        end
                    end
                    default: ;
                endcase
                if (!any_down) begin
                    active_next      = 1'b0;
                    tap_started_next = 1'b0;
                    rel_time_next    = item.timestamp;
                    rel_seen_next    = 1'b1;
                end
            end
        end
    end

    assign emit                 = emit_c;
    assign result.out_track     = item.track;
    assign result.out_timestamp = item.timestamp;
    assign result.out_x         = ox;
    assign result.out_y         = oy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg        <= '0;
            active_reg      <= 1'b0;
            tap_started_reg <= 1'b0;
            rel_seen_reg    <= 1'b0;
            hold_ref_reg    <= '0;
            tap_ref_reg     <= '0;
            rel_time_reg    <= '0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            anchor_x_reg    <= '0;
            anchor_y_reg    <= '0;
        end else if (fire) begin
            down_reg        <= down_next;
            active_reg      <= active_next;
            tap_started_reg <= tap_started_next;
            rel_seen_reg    <= rel_seen_next;
            hold_ref_reg    <= hold_ref_next;
            tap_ref_reg     <= tap_ref_next;
            rel_time_reg    <= rel_time_next;
            first_x_reg     <= first_x_next;
            first_y_reg     <= first_y_next;
            anchor_x_reg    <= anchor_x_next;
            anchor_y_reg    <= anchor_y_next;
        end
    end

endmodule

@@ rtl/touch_accommodation_filter.sv @@
// channel   dir  handshake                   contents
// s_        in   s_tvalid / s_tready         one touch sample per word
// m_        out  m_tvalid / m_tready         one filtered sample per word
// cfg_      in   cfg_valid / cfg_ready       register index and write data
//
// one word is taken per cycle unless the output stalls; a sample is held in the
// input register, runs through the filter logic and lands in the output register.
// the filter state loop closes through the state registers. aresetn is synchronous:
// it clears filter state, the config registers and the valid flags of both word
// registers. a stall on m_tready holds the output word; the input register still
// takes a word while it is empty, then s_tready follows m_tready.
module touch_accommodation_filter #(
    parameter int TRACKS = taf_pkg::TRACKS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // track[2:0], timestamp[34:3], x_pos[50:35], y_pos[66:51], zero fill
    input  logic [taf_pkg::S_DATA_W-1:0]   s_tdata,
    // trial_start
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_track[2:0], out_timestamp[34:3], out_x[50:35], out_y[66:51], zero fill
    output logic [taf_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [taf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [taf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import taf_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    fire, emit, s_accept;
    result_t result;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    taf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    taf_core #(
        .TRACKS (TRACKS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.trial_start   <= s_tuser;
            item_reg.track         <= s_tdata[2:0];
            item_reg.timestamp     <= s_tdata[34:3];
            item_reg.x_pos         <= s_tdata[50:35];
            item_reg.y_pos         <= s_tdata[66:51];
            item_reg.last_of_track <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.out_y, out_reg.out_x,
                       out_reg.out_timestamp, out_reg.out_track};

endmodule
